>>> rtl/core/fbrf_pkg.sv
// Shared types and register offsets for the framebuffer rectangle fill controller.
`default_nettype none
package fbrf_pkg;

    typedef struct packed {
        logic        kind;
        logic [1:0]  access_size;
        logic [23:0] address_offset;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        claimed;
        logic        fault;
    } rsp_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    localparam logic [23:0] OFS_PANEL0      = 24'h000980;
    localparam logic [23:0] OFS_PANEL1      = 24'h000984;
    localparam logic [23:0] OFS_PANEL2      = 24'h000988;
    localparam logic [23:0] OFS_PANEL3      = 24'h00098C;
    localparam logic [23:0] OFS_PANEL4      = 24'h000994;
    localparam logic [23:0] OFS_PANEL_NOP   = 24'h000998;
    localparam logic [23:0] OFS_PANEL5      = 24'h00099C;
    localparam logic [23:0] OFS_BLIT_GO     = 24'h000A00;
    localparam logic [23:0] OFS_BLIT_A      = 24'h000A04;
    localparam logic [23:0] OFS_BLIT_B      = 24'h000A08;
    localparam logic [23:0] OFS_BLIT_C      = 24'h000A10;
    localparam logic [23:0] OFS_BLIT_D      = 24'h000A14;
    localparam logic [23:0] OFS_FILL_CMD    = 24'h000200;
    localparam logic [23:0] OFS_FILL_COLOUR = 24'h000204;
    localparam logic [23:0] OFS_FILL_WIDTH  = 24'h000208;
    localparam logic [23:0] OFS_FILL_HEIGHT = 24'h00020C;
    localparam logic [23:0] OFS_FILL_DLO    = 24'h000210;
    localparam logic [23:0] OFS_FILL_DHI    = 24'h000214;
    localparam logic [23:0] OFS_FILL_GO     = 24'h000234;
    localparam logic [15:0] COLOUR_MASK     = 16'hFFFF;

    // Operation classes handed from the front to the back.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_RESP  = 3'd1,
        OP_FB_RD = 3'd2,
        OP_FB_WR = 3'd3,
        OP_FILL  = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  nbytes_m1;
        logic [23:0] fb_addr;
        logic [31:0] data;
        logic        claimed;
        logic        fault;
    } cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/fbrf_front.sv
// Front end: decodes accesses, keeps the registers and checks fill requests.
`default_nettype none
module fbrf_front #(
    parameter int FRAME_BYTES = 262144,
    parameter int FRAME_BASE = 65536,
    parameter int LINE_STRIDE_BYTES = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fbrf_pkg::req_t req,
    output fbrf_pkg::cmd_t     cmd,
    output logic [31:0]        fill_colour,
    output logic [31:0]        fill_width,
    output logic [31:0]        fill_height,
    output logic [31:0]        fill_start,
    input  wire logic          take
);
    logic [31:0] panel_reg [6];
    logic [31:0] cmd_reg, colour_reg, width_reg, height_reg, dlo_reg, dhi_reg;
    logic [31:0] start;
    logic [63:0] span, endp;
    logic        in_fb, is_wr, is_word, bad_fill;
    logic [2:0]  nb;
    logic [24:0] off_end;

    assign fill_colour = colour_reg;
    assign fill_width  = width_reg;
    assign fill_height = height_reg;
    assign fill_start  = start;

    assign start = {dhi_reg[15:0], dlo_reg[15:0]};
    assign span  = 64'(height_reg - 32'd1) * 64'(LINE_STRIDE_BYTES) + {31'd0, width_reg, 1'b0};
    assign endp  = 64'(start) + span;
    assign bad_fill = endp > 64'(FRAME_BYTES);

    assign is_wr   = req.kind;
    assign is_word = req.access_size == fbrf_pkg::SIZE_WORD;
    assign nb = (req.access_size == fbrf_pkg::SIZE_BYTE) ? 3'd1 :
                (req.access_size == fbrf_pkg::SIZE_HALF) ? 3'd2 : 3'd4;
    assign off_end = {1'b0, req.address_offset} + {22'd0, nb};
    assign in_fb = req.access_size != fbrf_pkg::SIZE_BAD
                && 32'(req.address_offset) >= 32'(FRAME_BASE)
                && 33'(off_end) <= 33'(FRAME_BASE) + 33'(FRAME_BYTES);

    always_comb
    begin
        cmd = '0;
        cmd.op = fbrf_pkg::OP_RESP;
        cmd.data = req.write_data;
        cmd.nbytes_m1 = 2'(nb - 3'd1);
        cmd.fb_addr = 24'(32'(req.address_offset) - 32'(FRAME_BASE));
        if (in_fb)
        begin
            cmd.claimed = 1'b1;
            cmd.op = is_wr ? fbrf_pkg::OP_FB_WR : fbrf_pkg::OP_FB_RD;
        end
        else if (is_word && !is_wr)
        begin
            cmd.data = '0;
            case (req.address_offset)
                fbrf_pkg::OFS_BLIT_GO, fbrf_pkg::OFS_FILL_GO: cmd.claimed = 1'b1;
                fbrf_pkg::OFS_PANEL0:
                begin
                    cmd.claimed = 1'b1;
                    cmd.data = panel_reg[0];
                end
                fbrf_pkg::OFS_PANEL4:
                begin
                    cmd.claimed = 1'b1;
                    cmd.data = panel_reg[4];
                end
                default: cmd.claimed = 1'b0;
            endcase
        end
        else if (is_word)
        begin
            cmd.data = '0;
            cmd.claimed = 1'b1;
            case (req.address_offset)
                fbrf_pkg::OFS_PANEL0, fbrf_pkg::OFS_PANEL1, fbrf_pkg::OFS_PANEL2,
                fbrf_pkg::OFS_PANEL3, fbrf_pkg::OFS_PANEL4, fbrf_pkg::OFS_PANEL5,
                fbrf_pkg::OFS_PANEL_NOP, fbrf_pkg::OFS_BLIT_A, fbrf_pkg::OFS_BLIT_B,
                fbrf_pkg::OFS_BLIT_C, fbrf_pkg::OFS_BLIT_D, fbrf_pkg::OFS_FILL_CMD,
                fbrf_pkg::OFS_FILL_COLOUR, fbrf_pkg::OFS_FILL_WIDTH,
                fbrf_pkg::OFS_FILL_HEIGHT, fbrf_pkg::OFS_FILL_DLO,
                fbrf_pkg::OFS_FILL_DHI: cmd.claimed = 1'b1;
                fbrf_pkg::OFS_BLIT_GO: cmd.fault = req.write_data != 32'd1;
                fbrf_pkg::OFS_FILL_GO:
                begin
                    if (req.write_data != 32'd1 || cmd_reg != 32'd0)
                        cmd.fault = 1'b1;
                    else if (width_reg != 32'd0 && height_reg != 32'd0)
                    begin
                        if (bad_fill)
                            cmd.fault = 1'b1;
                        else
                            cmd.op = fbrf_pkg::OP_FILL;
                    end
                end
                default: cmd.claimed = 1'b0;
            endcase
        end
        else
        begin
            cmd.data = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                panel_reg[i] <= '0;
            cmd_reg <= '0;
            colour_reg <= '0;
            width_reg <= '0;
            height_reg <= '0;
            dlo_reg <= '0;
            dhi_reg <= '0;
        end
        else if (take && is_word && is_wr && !in_fb)
        begin
            case (req.address_offset)
                fbrf_pkg::OFS_PANEL0: panel_reg[0] <= req.write_data;
                fbrf_pkg::OFS_PANEL1: panel_reg[1] <= req.write_data;
                fbrf_pkg::OFS_PANEL2: panel_reg[2] <= req.write_data;
                fbrf_pkg::OFS_PANEL3: panel_reg[3] <= req.write_data;
                fbrf_pkg::OFS_PANEL4: panel_reg[4] <= req.write_data;
                fbrf_pkg::OFS_PANEL5: panel_reg[5] <= req.write_data;
                fbrf_pkg::OFS_FILL_CMD: cmd_reg <= req.write_data;
                fbrf_pkg::OFS_FILL_COLOUR: colour_reg <= req.write_data;
                fbrf_pkg::OFS_FILL_WIDTH: width_reg <= req.write_data;
                fbrf_pkg::OFS_FILL_HEIGHT: height_reg <= req.write_data;
                fbrf_pkg::OFS_FILL_DLO: dlo_reg <= req.write_data;
                fbrf_pkg::OFS_FILL_DHI: dhi_reg <= req.write_data;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/fbrf_back.sv
// Back end: clears the frame store, runs byte accesses and rectangle fills.
`default_nettype none
module fbrf_back #(
    parameter int FRAME_BYTES = 262144,
    parameter int LINE_STRIDE_BYTES = 512
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire fbrf_pkg::cmd_t cmd,
    output logic                cmd_ready,
    input  wire logic [31:0]    fill_colour,
    input  wire logic [31:0]    fill_width,
    input  wire logic [31:0]    fill_height,
    input  wire logic [31:0]    fill_start,
    output logic                rsp_valid,
    output fbrf_pkg::rsp_t      rsp,
    input  wire logic           rsp_ready,
    output logic                busy
);
    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD    = 6'b000100,
        ST_WR    = 6'b001000,
        ST_FILL  = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  mem [FRAME_BYTES];
    logic [AW:0] clr_reg;
    fbrf_pkg::cmd_t cur_reg;
    logic [1:0]  idx_reg;
    logic [31:0] row_reg, col_reg;
    logic [AW:0] rowbase_reg, pos_reg;
    logic        hi_reg;
    logic [7:0]  rdq;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]  mem_wd;
    logic [1:0]  rd_lag_reg;
    fbrf_pkg::rsp_t rsp_reg;

    assign cmd_ready = state_reg == ST_IDLE;
    assign rsp_valid = state_reg == ST_RESP;
    assign rsp = rsp_reg;
    assign busy = state_reg != ST_IDLE;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg[AW-1:0];
            end
            ST_WR:
            begin
                mem_we = 1'b1;
                mem_wa = AW'(cur_reg.fb_addr) + AW'(idx_reg);
                mem_wd = cur_reg.data[8*idx_reg +: 8];
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg[AW-1:0] + AW'(hi_reg);
                mem_wd = hi_reg ? fill_colour[15:8] : fill_colour[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdq <= mem[AW'(cur_reg.fb_addr) + AW'(idx_reg)];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(FRAME_BYTES - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (cmd_valid)
                begin
                    case (cmd.op)
                        fbrf_pkg::OP_FB_RD: state_next = ST_RD;
                        fbrf_pkg::OP_FB_WR: state_next = ST_WR;
                        fbrf_pkg::OP_FILL:  state_next = ST_FILL;
                        default:            state_next = ST_RESP;
                    endcase
                end
            ST_RD: if (rd_lag_reg == 2'd1 && idx_reg == cur_reg.nbytes_m1) state_next = ST_RESP;
            ST_WR: if (idx_reg == cur_reg.nbytes_m1) state_next = ST_RESP;
            ST_FILL:
                if (hi_reg && col_reg == fill_width - 32'd1 && row_reg == fill_height - 32'd1)
                    state_next = ST_RESP;
            ST_RESP: if (rsp_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            idx_reg <= '0;
            rd_lag_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    rd_lag_reg <= '0;
                end
                ST_RD:
                begin
                    // wait for the registered read, then capture and advance
                    if (rd_lag_reg == 2'd0)
                        rd_lag_reg <= 2'd1;
                    else
                    begin
                        rd_lag_reg <= 2'd0;
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                ST_WR: idx_reg <= idx_reg + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= cmd;
                row_reg <= '0;
                col_reg <= '0;
                hi_reg <= 1'b0;
                rowbase_reg <= (AW+1)'(fill_start);
                pos_reg <= (AW+1)'(fill_start);
                rsp_reg.read_data <= cmd.data;
                rsp_reg.claimed <= cmd.claimed;
                rsp_reg.fault <= cmd.fault;
            end
            ST_RD:
                if (rd_lag_reg == 2'd1)
                begin
                    rsp_reg.read_data[8*idx_reg +: 8] <= rdq;
                    if (idx_reg == 2'd0)
                        rsp_reg.read_data[31:8] <= '0;
                end
            ST_WR: rsp_reg.read_data <= '0;
            ST_FILL:
            begin
                rsp_reg.read_data <= '0;
                hi_reg <= !hi_reg;
                if (hi_reg)
                begin
                    if (col_reg == fill_width - 32'd1)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 32'd1;
                        rowbase_reg <= rowbase_reg + (AW+1)'(LINE_STRIDE_BYTES);
                        pos_reg <= rowbase_reg + (AW+1)'(LINE_STRIDE_BYTES);
                    end
                    else
                    begin
                        col_reg <= col_reg + 32'd1;
                        pos_reg <= pos_reg + (AW+1)'(2);
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/framebuffer_rect_fill_controller.sv
// Top level of the framebuffer rectangle fill controller.
// Usage:
//   req channel (req_valid/req_ready, req) carries one bus access per item:
//   read or write of a byte, half or word. rsp channel (rsp_valid/rsp_ready,
//   rsp) returns one item per access: read data, claimed and fault.
//   After reset the frame store is cleared one byte a cycle, FRAME_BYTES
//   bytes (262144 by default); no item is accepted until that pass ends.
//   A fill GO that starts writes 2*width*height bytes, one byte per
//   cycle. The next item can be accepted in the cycle after the response
//   is taken. The front decodes the access, which is latched in a one-entry
//   queue; the back runs memory work and holds the response until rsp_ready.
//   While the back is busy or holds its response req_ready stays low, so a
//   stalled receiver stalls the sender.
`default_nettype none
module framebuffer_rect_fill_controller #(
    parameter int FRAME_BYTES = 262144,
    parameter int FRAME_BASE = 65536,
    parameter int LINE_STRIDE_BYTES = 512
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire fbrf_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output fbrf_pkg::rsp_t      rsp
);
    fbrf_pkg::cmd_t cmd_d, q_reg;
    logic q_valid_reg, back_ready, busy;
    logic [31:0] colour, width, height, start;
    logic take;

    // register writes must not run under a fill still in progress
    assign req_ready = !q_valid_reg && !busy;
    assign take = req_valid && req_ready;

    fbrf_front #(
        .FRAME_BYTES(FRAME_BYTES),
        .FRAME_BASE(FRAME_BASE),
        .LINE_STRIDE_BYTES(LINE_STRIDE_BYTES)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd_d),
        .fill_colour(colour), .fill_width(width), .fill_height(height),
        .fill_start(start), .take(take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (take)
            q_valid_reg <= 1'b1;
        else if (back_ready)
            q_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            q_reg <= cmd_d;
    end

    fbrf_back #(
        .FRAME_BYTES(FRAME_BYTES),
        .LINE_STRIDE_BYTES(LINE_STRIDE_BYTES)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid_reg), .cmd(q_reg),
        .cmd_ready(back_ready), .fill_colour(colour), .fill_width(width),
        .fill_height(height), .fill_start(start), .rsp_valid(rsp_valid),
        .rsp(rsp), .rsp_ready(rsp_ready), .busy(busy)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !req_ready) else $error("item accepted while back busy");
    a_fault_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fault |-> rsp.claimed) else $error("fault without claim");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed under stall");
endmodule
`default_nettype wire
